### rtl/spq_pkg.sv
// Package: item types, operation and status codes, controller/datapath links
package spq_pkg;

  localparam int unsigned IdW    = 16;
  localparam int unsigned PrioW  = 16;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_POP     = 2'd1,
    OP_UPGRADE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    op_e              op;
    logic [IdW-1:0]   entry_id;
    logic [PrioW-1:0] priority_req;
  } in_t;

  typedef struct packed {
    status_e           status;
    logic [IdW-1:0]    popped_id;
    logic [IdW-1:0]    front_id;
    logic [PrioW-1:0]  front_priority;
    logic              is_empty;
    logic [CountW-1:0] count;
  } out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic exec;      // apply the accepted item's operation
    logic reinsert;  // second pass of an upgrade: insert the held request
    logic load_out;  // capture the result into the output register
  } ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic reinsert_req;  // the item being accepted is an upgrade that removed an entry
  } sts_t;

endpackage

### rtl/spq_ctrl.sv
// Controller: sequences accept, upgrade reinsert pass and result hand-off
module spq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  spq_pkg::sts_t sts_i,
  output spq_pkg::ctl_t ctl_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_INS  = 3'b010,
    S_RES  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Decode state into datapath commands
  always_comb begin
    ctl_o          = '0;
    ctl_o.exec     = in_ready_o && in_valid_i;
    ctl_o.reinsert = (state_q == S_INS);
    ctl_o.load_out = (state_q == S_RES) && out_free;
  end

  // Advance the sequence
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (ctl_o.exec) begin
          state_d = sts_i.reinsert_req ? S_INS : S_RES;
        end
      end
      S_INS: begin
        state_d = S_RES;
      end
      S_RES: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold the result valid until taken
  always_comb begin
    if (ctl_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/spq_datapath.sv
// Datapath: sorted cell array with parallel compare, request and result registers
module spq_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  spq_pkg::in_t  in_item_i,
  input  spq_pkg::ctl_t ctl_i,
  output spq_pkg::sts_t sts_o,
  output spq_pkg::out_t out_item_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [spq_pkg::IdW-1:0]   slot_id_q [DEPTH];
  logic [spq_pkg::IdW-1:0]   slot_id_d [DEPTH];
  logic [spq_pkg::PrioW-1:0] slot_pr_q [DEPTH];
  logic [spq_pkg::PrioW-1:0] slot_pr_d [DEPTH];
  logic [CW-1:0]             fill_q, fill_d;

  logic [spq_pkg::IdW-1:0]   req_id_q;
  logic [spq_pkg::PrioW-1:0] req_pr_q;
  spq_pkg::status_e          status_q, status_d;
  logic [spq_pkg::IdW-1:0]   popped_q, popped_d;
  spq_pkg::out_t             out_q, out_d;

  logic [spq_pkg::IdW-1:0]   ins_id;
  logic [spq_pkg::PrioW-1:0] ins_pr;
  logic [DEPTH-1:0]          le, match, seen;
  logic                      is_full, is_empty, found;
  logic                      do_ins, do_rem, do_clr, rem_pop;

  assign is_full  = (fill_q == CW'(DEPTH));
  assign is_empty = (fill_q == '0);
  assign found    = seen[DEPTH-1];

  // Pick the entry to insert: the new item, or the held upgrade request
  assign ins_id = ctl_i.reinsert ? req_id_q : in_item_i.entry_id;
  assign ins_pr = ctl_i.reinsert ? req_pr_q : in_item_i.priority_req;

  assign rem_pop = ctl_i.exec && (in_item_i.op == spq_pkg::OP_POP) && !is_empty;
  assign do_ins  = ctl_i.reinsert
                || (ctl_i.exec && (in_item_i.op == spq_pkg::OP_INSERT) && !is_full);
  assign do_rem  = rem_pop
                || (ctl_i.exec && (in_item_i.op == spq_pkg::OP_UPGRADE) && found);
  assign do_clr  = ctl_i.exec && (in_item_i.op == spq_pkg::OP_CLEAR);

  assign sts_o.reinsert_req = (in_item_i.op == spq_pkg::OP_UPGRADE) && found;

  // Per-cell compare and next value
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic valid_k, pos_k, shift_k;

    assign valid_k  = (CW'(k) < fill_q);
    assign le[k]    = valid_k && (slot_pr_q[k] <= ins_pr);
    assign match[k] = valid_k && (slot_id_q[k] == in_item_i.entry_id)
                   && (slot_pr_q[k] > in_item_i.priority_req);

    if (k == 0) begin : g_head
      assign seen[k] = match[k];
      assign pos_k   = !le[k];
    end else begin : g_body
      assign seen[k] = match[k] || seen[k-1];
      assign pos_k   = !le[k] && le[k-1];
    end

    assign shift_k = rem_pop || seen[k];

    always_comb begin
      slot_id_d[k] = slot_id_q[k];
      slot_pr_d[k] = slot_pr_q[k];
      if (do_ins && !le[k]) begin
        if (pos_k) begin
          slot_id_d[k] = ins_id;
          slot_pr_d[k] = ins_pr;
        end else if (k > 0) begin
          slot_id_d[k] = slot_id_q[(k > 0) ? k - 1 : 0];
          slot_pr_d[k] = slot_pr_q[(k > 0) ? k - 1 : 0];
        end
      end else if (do_rem && shift_k && (k < DEPTH - 1)) begin
        slot_id_d[k] = slot_id_q[(k < DEPTH - 1) ? k + 1 : k];
        slot_pr_d[k] = slot_pr_q[(k < DEPTH - 1) ? k + 1 : k];
      end
    end
  end

  // Update the fill count
  always_comb begin
    fill_d = fill_q;
    if (do_clr) begin
      fill_d = '0;
    end else if (do_ins) begin
      fill_d = fill_q + CW'(1);
    end else if (do_rem) begin
      fill_d = fill_q - CW'(1);
    end
  end

  // Form status and popped id of the accepted item
  always_comb begin
    status_d = status_q;
    popped_d = popped_q;
    if (ctl_i.exec) begin
      status_d = spq_pkg::ST_OK;
      popped_d = '0;
      case (in_item_i.op)
        spq_pkg::OP_INSERT: begin
          if (is_full) status_d = spq_pkg::ST_FULL;
        end
        spq_pkg::OP_POP: begin
          if (is_empty) status_d = spq_pkg::ST_EMPTY;
          else popped_d = slot_id_q[0];
        end
        spq_pkg::OP_UPGRADE: begin
          if (!found) status_d = spq_pkg::ST_NOT_FOUND;
        end
        default: begin
          status_d = spq_pkg::ST_OK;
        end
      endcase
    end
  end

  // Build the result from the queue after the operation
  always_comb begin
    out_d                = out_q;
    if (ctl_i.load_out) begin
      out_d.status         = status_q;
      out_d.popped_id      = popped_q;
      out_d.is_empty       = is_empty;
      out_d.count          = spq_pkg::CountW'(fill_q);
      out_d.front_id       = is_empty ? '0 : slot_id_q[0];
      out_d.front_priority = is_empty ? '0 : slot_pr_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_id_q[i] <= slot_id_d[i];
      slot_pr_q[i] <= slot_pr_d[i];
    end
    if (ctl_i.exec) begin
      req_id_q <= in_item_i.entry_id;
      req_pr_q <= in_item_i.priority_req;
    end
    status_q <= status_d;
    popped_q <= popped_d;
    out_q    <= out_d;
  end

  assign out_item_o = out_q;

endmodule

### rtl/sorted_priority_queue_with_upgrade.sv
// Top level: sorted priority queue with upgrade, controller plus cell-array datapath
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_ready_o   in_item_i  (spq_pkg::in_t)
//   out       output     out_valid_o / out_ready_i out_item_o (spq_pkg::out_t)
//
// Each item passes through apply, then load result; an upgrade that removes its entry adds
// a reinsert pass through the same cell array between the remove and the load.
// The result register loads in the result state, once the output register is free.
// The next item is accepted once the result is in the output register.
// Reset empties the queue; slot contents are left as they are.
// A stalled output lets one more item in; that item waits in the result state.
module sorted_priority_queue_with_upgrade #(
  parameter int unsigned DEPTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  spq_pkg::in_t  in_item_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output spq_pkg::out_t out_item_o
);

  spq_pkg::ctl_t ctl;
  spq_pkg::sts_t sts;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .out_item_o (out_item_o)
  );

`ifndef SYNTHESIS
  // An upgrade that removed an entry must be followed by its reinsert pass
  a_reinsert_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.exec && sts.reinsert_req |=> ctl.reinsert)
    else $error("upgrade reinsert pass missing");

  // A result is loaded only when the output register is free
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.load_out |-> (!out_valid_o || out_ready_i))
    else $error("result overwritten before taken");

  // No item is taken during a reinsert pass
  a_no_accept_reinsert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.reinsert |-> !in_ready_o)
    else $error("item accepted during reinsert");

  // An empty result reports a zero front id and front priority
  a_empty_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.is_empty |->
      (out_item_o.front_id == '0) && (out_item_o.front_priority == '0))
    else $error("empty result with nonzero front");
`endif

endmodule
